[src/http_chunked_body_decoder_unit_defines.svh]
// Assertion helpers used by the decoder core.
// Each macro expects signals named clk and arst_n in the module that uses it.
`ifndef HTTP_CHUNKED_BODY_DECODER_UNIT_DEFINES_SVH
`define HTTP_CHUNKED_BODY_DECODER_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define HCBD_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("hcbd assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define HCBD_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("hcbd assertion failed");

`endif

[src/hcbd_pkg.sv]
package hcbd_pkg;

	// Default width of the chunk size counter.
	localparam int SIZE_BITS_DEFAULT = 32;

	// Configuration port geometry.
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;
	localparam logic REG_CHUNKED_MODE = 1'b0;

	// Characters that steer the framing.
	localparam logic [7:0] CHAR_LF    = 8'h0A;
	localparam logic [7:0] CHAR_CR    = 8'h0D;
	localparam logic [7:0] CHAR_TAB   = 8'h09;
	localparam logic [7:0] CHAR_VT    = 8'h0B;
	localparam logic [7:0] CHAR_FF    = 8'h0C;
	localparam logic [7:0] CHAR_SPACE = 8'h20;

	// Bytes discarded after the data of each chunk.
	localparam logic [1:0] TRAILER_BYTES = 2'd2;

	// One result word as it leaves the decoder.
	typedef struct packed {
		logic [7:0] out_byte;
		logic       out_valid;
		logic       body_done;
		logic       size_overflow;
	} res_t;

endpackage

[src/hcbd_ifs.sv]
// Input channel: one raw body byte per word.
interface hcbd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       body_start;

	modport source (output valid, output in_byte, output body_start, input ready);
	modport sink (input valid, input in_byte, input body_start, output ready);
endinterface

// Output channel: one result word for each input word.
interface hcbd_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       out_valid;
	logic       body_done;
	logic       size_overflow;

	modport source (output valid, output out_byte, output out_valid, output body_done,
		output size_overflow, input ready);
	modport sink (input valid, input out_byte, input out_valid, input body_done,
		input size_overflow, output ready);
endinterface

[src/http_chunked_body_decoder_unit.sv]
// A result word is registered and presented in the cycle after its input word is accepted.
// Throughput: one word per cycle; the single-step framing update and the output
// register set that figure, and the input is stalled only while the output is held.
// Reset: arst_n clears the framing state, the sticky overflow flag, the output valid
// and the chunked_mode register (pass-through) at once; no clearing pass is needed.
module http_chunked_body_decoder_unit #(
	parameter int SIZE_BITS = hcbd_pkg::SIZE_BITS_DEFAULT
) (
	input  logic                         clk,
	input  logic                         arst_n,
	hcbd_in_if.sink                      in_ch,
	hcbd_out_if.source                   out_ch,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [hcbd_pkg::PADDR_W-1:0] paddr,
	input  logic [hcbd_pkg::PDATA_W-1:0] pwdata,
	output logic [hcbd_pkg::PDATA_W-1:0] prdata,
	output logic                         pready
);

	logic           chunked_mode;
	logic           in_accept;
	logic           space;
	logic           out_valid_q;
	hcbd_pkg::res_t res;
	hcbd_pkg::res_t res_q;

	// The single configuration register, chunked_mode, lives behind the APB port.
	hcbd_cfg u_cfg (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.chunked_mode (chunked_mode)
	);

	// A word is taken whenever the output register has room, so the decoder stalls
	// while a finished result waits for the downstream side.
	assign in_ch.ready = space;
	assign in_accept   = in_ch.valid && space;

	// The decoder works out the framing for the accepted byte in the same cycle and
	// updates its phase, remaining count and trailer count at the accepting edge.
	hcbd_core #(
		.SIZE_BITS (SIZE_BITS)
	) u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.chunked_mode (chunked_mode),
		.in_accept    (in_accept),
		.in_byte      (in_ch.in_byte),
		.body_start   (in_ch.body_start),
		.res          (res)
	);

	// Every input word yields exactly one result word, held here until taken.
	hcbd_outreg u_outreg (
		.clk         (clk),
		.arst_n      (arst_n),
		.load        (in_accept),
		.res         (res),
		.out_ready   (out_ch.ready),
		.out_valid_q (out_valid_q),
		.res_q       (res_q),
		.space       (space)
	);

	assign out_ch.valid         = out_valid_q;
	assign out_ch.out_byte      = res_q.out_byte;
	assign out_ch.out_valid     = res_q.out_valid;
	assign out_ch.body_done     = res_q.body_done;
	assign out_ch.size_overflow = res_q.size_overflow;

endmodule

[src/hcbd_cfg.sv]
module hcbd_cfg (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [hcbd_pkg::PADDR_W-1:0] paddr,
	input  logic [hcbd_pkg::PDATA_W-1:0] pwdata,
	output logic [hcbd_pkg::PDATA_W-1:0] prdata,
	output logic                         pready,
	output logic                         chunked_mode
);

	logic chunked_mode_q;
	logic reg_index;
	logic wr_en;

	// Registers sit on 32-bit boundaries, so bit 2 picks the register.
	assign reg_index = paddr[2];
	assign pready    = 1'b1;
	assign wr_en     = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chunked_mode_q <= 1'b0;
		end else if (wr_en && (reg_index == hcbd_pkg::REG_CHUNKED_MODE)) begin
			chunked_mode_q <= pwdata[0];
		end
	end

	always_comb begin
		prdata = '0;
		if (reg_index == hcbd_pkg::REG_CHUNKED_MODE) begin
			prdata[0] = chunked_mode_q;
		end
	end

	assign chunked_mode = chunked_mode_q;

endmodule

[src/hcbd_core.sv]
`include "http_chunked_body_decoder_unit_defines.svh"

module hcbd_core #(
	parameter int SIZE_BITS = hcbd_pkg::SIZE_BITS_DEFAULT
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             chunked_mode,
	input  logic             in_accept,
	input  logic [7:0]       in_byte,
	input  logic             body_start,
	output hcbd_pkg::res_t   res
);

	typedef enum logic [2:0] {
		PH_LEAD   = 3'd0,
		PH_DIGITS = 3'd1,
		PH_TAIL   = 3'd2,
		PH_DATA   = 3'd3,
		PH_SKIP   = 3'd4,
		PH_DONE   = 3'd5
	} phase_t;

	phase_t               phase_q, ph_s, ph_n;
	logic [SIZE_BITS-1:0] rem_q, rem_s, rem_n, rem_dec;
	logic [1:0]           skip_q, skip_s, skip_n, skip_dec;
	logic                 ovf_q, ovf_s, ovf_n;
	logic                 is_lf, is_blank, is_hex, line_end, valid, done;
	logic [3:0]           hex_d;

	always_comb begin
		is_hex = 1'b1;
		hex_d  = 4'd0;
		if (in_byte >= 8'h30 && in_byte <= 8'h39) begin
			hex_d = 4'(in_byte - 8'h30);
		end else if (in_byte >= 8'h61 && in_byte <= 8'h66) begin
			hex_d = 4'(in_byte - 8'h57);
		end else if (in_byte >= 8'h41 && in_byte <= 8'h46) begin
			hex_d = 4'(in_byte - 8'h37);
		end else begin
			is_hex = 1'b0;
		end
	end

	assign is_lf    = (in_byte == hcbd_pkg::CHAR_LF);
	assign is_blank = (in_byte == hcbd_pkg::CHAR_SPACE) || (in_byte == hcbd_pkg::CHAR_TAB) ||
		(in_byte == hcbd_pkg::CHAR_VT) || (in_byte == hcbd_pkg::CHAR_FF) ||
		(in_byte == hcbd_pkg::CHAR_CR);

	// A new body restarts the framing before the byte itself is looked at.
	assign ph_s   = body_start ? PH_LEAD : phase_q;
	assign rem_s  = body_start ? '0 : rem_q;
	assign skip_s = body_start ? 2'd0 : skip_q;
	assign ovf_s  = body_start ? 1'b0 : ovf_q;

	assign rem_dec  = rem_s - SIZE_BITS'(1);
	assign skip_dec = skip_s - 2'd1;

	always_comb begin
		ph_n     = ph_s;
		rem_n    = rem_s;
		skip_n   = skip_s;
		ovf_n    = ovf_s;
		valid    = 1'b0;
		done     = 1'b0;
		line_end = 1'b0;
		if (!chunked_mode) begin
			valid = 1'b1;
		end else begin
			unique case (ph_s)
				PH_LEAD, PH_DIGITS: begin
					if (is_lf) begin
						line_end = 1'b1;
					end else if (is_hex) begin
						// The size saturates once any bit of the top digit is set.
						if (rem_s[SIZE_BITS-1 -: 4] != 4'd0) begin
							rem_n = '1;
							ovf_n = 1'b1;
						end else begin
							rem_n = {rem_s[SIZE_BITS-5:0], hex_d};
						end
						ph_n = PH_DIGITS;
					end else if (!(is_blank && (ph_s == PH_LEAD))) begin
						ph_n = PH_TAIL;
					end
				end
				PH_TAIL: begin
					line_end = is_lf;
				end
				PH_DATA: begin
					valid = 1'b1;
					rem_n = rem_dec;
					if (rem_dec == '0) begin
						ph_n   = PH_SKIP;
						skip_n = hcbd_pkg::TRAILER_BYTES;
					end
				end
				PH_SKIP: begin
					skip_n = skip_dec;
					if (skip_dec == 2'd0) begin
						ph_n = PH_LEAD;
					end
				end
				default: begin
				end
			endcase
			if (line_end) begin
				if (rem_s == '0) begin
					ph_n = PH_DONE;
					done = 1'b1;
				end else begin
					ph_n = PH_DATA;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_LEAD;
			rem_q   <= '0;
			skip_q  <= 2'd0;
			ovf_q   <= 1'b0;
		end else if (in_accept) begin
			phase_q <= ph_n;
			rem_q   <= rem_n;
			skip_q  <= skip_n;
			ovf_q   <= ovf_n;
		end
	end

	assign res.out_byte      = valid ? in_byte : 8'd0;
	assign res.out_valid     = valid;
	assign res.body_done     = done;
	assign res.size_overflow = ovf_n;

	`HCBD_ASSERT_SAME(a_data_has_bytes, phase_q == PH_DATA, rem_q != '0)
	`HCBD_ASSERT_SAME(a_skip_has_count, phase_q == PH_SKIP, skip_q != 2'd0)
	`HCBD_ASSERT_NEXT(a_ovf_sticky, ovf_q && !(in_accept && body_start), ovf_q)

endmodule

[src/hcbd_outreg.sv]
module hcbd_outreg (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           load,
	input  hcbd_pkg::res_t res,
	input  logic           out_ready,
	output logic           out_valid_q,
	output hcbd_pkg::res_t res_q,
	output logic           space
);

	// Room for a new word when empty or when the held word leaves this cycle.
	assign space = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res;
		end
	end

endmodule

[tb/tb.sv]
module tb;

	// Width of the chunk size counter; the block is built with its default.
	localparam int COUNT_W = hcbd_pkg::SIZE_BITS_DEFAULT;
	// Widths of the configuration port.
	localparam int ADDR_W = hcbd_pkg::PADDR_W;
	localparam int DATA_W = hcbd_pkg::PDATA_W;
	// Byte address of the chunked_mode register on the configuration port.
	localparam logic [ADDR_W-1:0] MODE_ADDR = ADDR_W'(4 * hcbd_pkg::REG_CHUNKED_MODE);
	// The run is abandoned as hung after this many clock cycles.
	localparam int CYCLE_LIMIT = 200000;
	// Length of the long receiver hold-off that fills the block up.
	localparam int HOLD_CYCLES = 60;

	// The scoreboard keeps its own copy of the framing state and of the mode
	// register. It works out the result word that each accepted input word must
	// produce and holds those words in order until the block delivers them.
	class chunk_scoreboard;
		typedef enum logic [2:0] {
			LINE_LEAD,
			LINE_DIGITS,
			LINE_TAIL,
			IN_DATA,
			IN_TRAILER,
			BODY_END
		} frame_state_t;

		bit                 chunked;
		frame_state_t       state;
		logic [COUNT_W-1:0] remaining;
		logic [1:0]         trailer_left;
		bit                 overflow;
		hcbd_pkg::res_t     expected_q[$];
		int                 errors;
		int                 words;
		int                 payload;
		int                 ends;
		int                 flagged;

		function new();
			chunked = 1'b0;
			restart();
		endfunction

		function void restart();
			state = LINE_LEAD;
			remaining = '0;
			trailer_left = '0;
			overflow = 1'b0;
		endfunction

		function int hex_value(logic [7:0] c);
			if (c >= "0" && c <= "9") return int'(c - "0");
			if (c >= "a" && c <= "f") return int'(c - "a") + 10;
			if (c >= "A" && c <= "F") return int'(c - "A") + 10;
			return -1;
		endfunction

		function bit is_blank(logic [7:0] c);
			return c == hcbd_pkg::CHAR_SPACE || c == hcbd_pkg::CHAR_TAB ||
				c == hcbd_pkg::CHAR_VT || c == hcbd_pkg::CHAR_FF ||
				c == hcbd_pkg::CHAR_CR;
		endfunction

		task report(string msg);
			$display("mismatch at %0t: %s", $time, msg);
			errors++;
		endtask

		// Works out the result of one accepted input word and queues it.
		function void note_word(logic [7:0] c, logic start);
			logic [COUNT_W-1:0] mx;
			logic [COUNT_W-1:0] dig;
			int                 d;
			bit                 line_end;
			bit                 pass;
			bit                 done;
			hcbd_pkg::res_t     want;

			line_end = 1'b0;
			pass = 1'b0;
			done = 1'b0;
			mx = '1;
			words++;
			if (start)
				restart();

			if (!chunked) begin
				pass = 1'b1;
			end else begin
				case (state)
					LINE_LEAD, LINE_DIGITS: begin
						if (c == hcbd_pkg::CHAR_LF) begin
							line_end = 1'b1;
						end else if (!(state == LINE_LEAD && is_blank(c))) begin
							d = hex_value(c);
							if (d >= 0) begin
								dig = COUNT_W'(d);
								// Saturate rather than wrap when the size outgrows the counter.
								if (remaining > ((mx - dig) >> 4)) begin
									remaining = mx;
									overflow = 1'b1;
								end else begin
									remaining = (remaining << 4) + dig;
								end
								state = LINE_DIGITS;
							end else begin
								state = LINE_TAIL;
							end
						end
					end
					LINE_TAIL: begin
						if (c == hcbd_pkg::CHAR_LF)
							line_end = 1'b1;
					end
					IN_DATA: begin
						pass = 1'b1;
						remaining = remaining - 1'b1;
						if (remaining == '0) begin
							state = IN_TRAILER;
							trailer_left = hcbd_pkg::TRAILER_BYTES;
						end
					end
					IN_TRAILER: begin
						trailer_left = trailer_left - 1'b1;
						if (trailer_left == '0)
							state = LINE_LEAD;
					end
					default: ;
				endcase
				if (line_end) begin
					if (remaining == '0) begin
						state = BODY_END;
						done = 1'b1;
					end else begin
						state = IN_DATA;
					end
				end
			end

			want.out_byte = pass ? c : 8'h00;
			want.out_valid = pass;
			want.body_done = done;
			want.size_overflow = overflow;
			expected_q.push_back(want);
		endfunction

		// Compares one delivered result word with the oldest one outstanding.
		task check_word(hcbd_pkg::res_t got);
			hcbd_pkg::res_t want;

			if (expected_q.size() == 0) begin
				report($sformatf("result word %h arrived with nothing outstanding", got));
				return;
			end
			want = expected_q.pop_front();
			if (got.out_byte !== want.out_byte)
				report($sformatf("out_byte %h, expected %h", got.out_byte, want.out_byte));
			if (got.out_valid !== want.out_valid)
				report($sformatf("out_valid %b, expected %b", got.out_valid, want.out_valid));
			if (got.body_done !== want.body_done)
				report($sformatf("body_done %b, expected %b", got.body_done, want.body_done));
			if (got.size_overflow !== want.size_overflow)
				report($sformatf("size_overflow %b, expected %b", got.size_overflow,
					want.size_overflow));
			payload += want.out_valid;
			ends += want.body_done;
			flagged += want.size_overflow;
		endtask
	endclass

	logic                clk;
	logic                arst_n;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [ADDR_W-1:0]   paddr;
	logic [DATA_W-1:0]   pwdata;
	logic [DATA_W-1:0]   prdata;
	logic                pready;

	hcbd_in_if  in_ch();
	hcbd_out_if out_ch();

	chunk_scoreboard sb = new();

	// Percentages of cycles in which the sender idles and the receiver stalls.
	int             idle_pct = 0;
	int             stall_pct = 0;
	bit             hold_req = 1'b0;
	bit             hold_off = 1'b0;
	int             cycle_count = 0;
	hcbd_pkg::res_t seen_word;

	// Bytes of the body under construction, sent in order by send_frame.
	logic [7:0] frame[$];

	http_chunked_body_decoder_unit uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_ch   (in_ch),
		.out_ch  (out_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// A hung block must not keep the simulator busy for ever.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("tb: errors");
			$finish;
		end
	end

	// Both channels are sampled at the rising edge. The input word is noted
	// first so that the queue is always in step, whatever the block's latency.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_ch.valid && in_ch.ready)
				sb.note_word(in_ch.in_byte, in_ch.body_start);
			if (out_ch.valid && out_ch.ready) begin
				seen_word.out_byte = out_ch.out_byte;
				seen_word.out_valid = out_ch.out_valid;
				seen_word.body_done = out_ch.body_done;
				seen_word.size_overflow = out_ch.size_overflow;
				sb.check_word(seen_word);
			end
		end
	end

	// The receiver stalls at random, and always while a hold-off is running.
	initial begin
		out_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			out_ch.ready <= !hold_off && ($urandom_range(99) >= stall_pct);
		end
	end

	// The long hold-off is timed here, so that the sender carries on offering
	// words meanwhile and the block has to stall its input.
	initial begin
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				hold_off = 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_off = 1'b0;
			end
		end
	end

	// Offers one word, with random idle cycles in front of it, and returns at
	// the rising edge at which the block takes it.
	task automatic send_word(logic [7:0] b, logic start);
		while ($urandom_range(99) < idle_pct) begin
			@(negedge clk);
			in_ch.valid <= 1'b0;
		end
		@(negedge clk);
		in_ch.valid <= 1'b1;
		in_ch.in_byte <= b;
		in_ch.body_start <= start;
		@(posedge clk);
		while (!in_ch.ready)
			@(posedge clk);
	endtask

	// Sends frame[from .. upto-1]; the first byte of the frame opens a new body.
	task automatic send_frame(int from, int upto);
		for (int i = from; i < upto; i++)
			send_word(frame[i], i == 0);
	endtask

	// The mode register is only touched while the block is idle: the input is
	// withdrawn and every outstanding result word has to have come back first.
	// The value is read back afterwards.
	task automatic set_chunked(bit on);
		@(negedge clk);
		in_ch.valid <= 1'b0;
		while (sb.expected_q.size() != 0)
			@(posedge clk);
		repeat (2) @(posedge clk);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= MODE_ADDR;
		pwdata <= {{(DATA_W - 1){1'b0}}, on};
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		sb.chunked = on;
		@(negedge clk);
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		if (prdata[0] !== on)
			sb.report($sformatf("chunked_mode reads back %b, expected %b", prdata[0], on));
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	function automatic void put_text(string s);
		for (int i = 0; i < s.len(); i++)
			frame.push_back(s[i]);
	endfunction

	// A hex digit in either case, chosen afresh for each digit.
	function automatic logic [7:0] hex_char(int d);
		if (d < 10)
			return 8'("0" + d);
		return ($urandom_range(1) != 0) ? 8'("A" + d - 10) : 8'("a" + d - 10);
	endfunction

	function automatic logic [7:0] any_blank();
		case ($urandom_range(4))
			0: return hcbd_pkg::CHAR_SPACE;
			1: return hcbd_pkg::CHAR_TAB;
			2: return hcbd_pkg::CHAR_VT;
			3: return hcbd_pkg::CHAR_FF;
			default: return hcbd_pkg::CHAR_CR;
		endcase
	endfunction

	// A chunk-size line for the value v, with optional leading blanks, leading
	// zeros, an extension or junk after the digits, and LF or CR LF at the end.
	// Extra digits beyond the value push the size past the counter.
	function automatic void put_size_line(logic [31:0] v, int extra);
		int nd;

		repeat ($urandom_range(2)) frame.push_back(any_blank());
		nd = 1;
		while (nd < 8 && (v >> (4 * nd)) != 0)
			nd++;
		if ($urandom_range(3) == 0)
			nd += $urandom_range(1, 2);
		for (int i = nd - 1; i >= 0; i--)
			frame.push_back(hex_char(int'((v >> (4 * i)) & 32'hF)));
		repeat (extra) frame.push_back(hex_char($urandom_range(15)));
		case ($urandom_range(5))
			0: put_text(";ext=1");
			1: put_text(" ; q");
			2: put_text("g");
			default: ;
		endcase
		if ($urandom_range(3) != 0)
			frame.push_back(hcbd_pkg::CHAR_CR);
		frame.push_back(hcbd_pkg::CHAR_LF);
	endfunction

	// Builds one random body. Most are well-formed chunked bodies with random
	// sizes, data and terminators; some are cut short, some carry a size at or
	// beyond the counter's limit and are then abandoned, and a few are noise.
	function automatic void build_body();
		int kind;
		int n;
		int cut;

		frame.delete();
		kind = $urandom_range(99);
		if (kind < 82) begin
			repeat ($urandom_range(1, 3)) begin
				n = ($urandom_range(7) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
				put_size_line(n, 0);
				repeat (n) frame.push_back(8'($urandom_range(255)));
				if ($urandom_range(9) == 0) begin
					frame.push_back(8'($urandom_range(255)));
					frame.push_back(8'($urandom_range(255)));
				end else begin
					put_text("\r\n");
				end
			end
			// The terminating line takes several forms; a line with no digits,
			// a sign or a 0x prefix all read as a zero size.
			case ($urandom_range(5))
				0: put_text("\n");
				1: put_text("\r\n");
				2: put_text("000\r\n");
				3: put_text("-3\r\n");
				4: put_text("0x1F\r\n");
				default: put_text("0\r\n");
			endcase
			// Bytes after the end of the body are dropped by the block.
			repeat ($urandom_range(4)) frame.push_back(8'($urandom_range(255)));
			if (kind >= 72) begin
				cut = $urandom_range(1, frame.size() - 1);
				while (frame.size() > cut)
					frame.pop_back();
			end
		end else if (kind < 92) begin
			if ($urandom_range(2) == 0)
				put_size_line(32'hFFFF_FFFF, 0);
			else
				put_size_line($urandom | 32'h1000_0000, $urandom_range(1, 3));
			repeat ($urandom_range(3, 10)) frame.push_back(8'($urandom_range(255)));
		end else begin
			repeat ($urandom_range(5, 20)) begin
				case ($urandom_range(4))
					0: frame.push_back(8'($urandom_range(255)));
					1: frame.push_back(hex_char($urandom_range(15)));
					2: frame.push_back(hcbd_pkg::CHAR_LF);
					3: frame.push_back(any_blank());
					default: put_text("x");
				endcase
			end
		end
	endfunction

	initial begin
		int sent;
		int cut;

		arst_n = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.in_byte = 8'h00;
		in_ch.body_start = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed part. The block leaves reset in pass-through, so the two
		// extreme byte values go straight through first.
		frame.delete();
		frame.push_back(8'h00);
		frame.push_back(8'hFF);
		send_frame(0, frame.size());

		set_chunked(1'b1);

		// Leading blanks, an extension after the size, the extreme data bytes,
		// a terminating line with no digits and a byte after the end.
		frame.delete();
		put_text("\t 2;\r\n");
		frame.push_back(8'h00);
		frame.push_back(8'hFF);
		put_text("\r\n\nZ");
		send_frame(0, frame.size());

		// Nine digits in mixed case saturate the size counter.
		frame.delete();
		put_text("fFfFfFfFf\n");
		send_frame(0, frame.size());

		// A 0x prefix stops at the x, so the size is zero and the body ends;
		// the new body also clears the overflow flag.
		frame.delete();
		put_text("0x1\n");
		send_frame(0, frame.size());

		// Random part, in four idling phases. Each phase decodes a run of
		// bodies, leaves one body part way through, passes random words through
		// in pass-through mode and then finishes the interrupted body.
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin
					idle_pct = 0;
					stall_pct = 0;
				end
				1: begin
					idle_pct = 78;
					stall_pct = 0;
				end
				2: begin
					idle_pct = 0;
					stall_pct = 78;
				end
				default: begin
					idle_pct = 26;
					stall_pct = 26;
				end
			endcase

			set_chunked(1'b1);
			if (ph == 0)
				hold_req = 1'b1;
			sent = 0;
			while (sent < 120) begin
				build_body();
				send_frame(0, frame.size());
				sent += frame.size();
			end

			frame.delete();
			put_size_line(20, 0);
			repeat (20) frame.push_back(8'($urandom_range(255)));
			put_text("\r\n0\r\n");
			cut = $urandom_range(1, frame.size() - 1);
			send_frame(0, cut);

			set_chunked(1'b0);
			repeat (30) send_word(8'($urandom_range(255)), $urandom_range(11) == 0);

			set_chunked(1'b1);
			send_frame(cut, frame.size());
		end

		@(negedge clk);
		in_ch.valid <= 1'b0;
		while (sb.expected_q.size() != 0)
			@(posedge clk);
		repeat (5) @(posedge clk);

		$display("summary: %0d words decoded in chunked and pass-through modes, %0d payload",
			sb.words, sb.payload);
		$display("summary: %0d body ends, %0d words with the overflow flag, four idling phases",
			sb.ends, sb.flagged);
		if (sb.errors == 0 && sb.expected_q.size() == 0)
			$display("tb: clean");
		else
			$display("tb: errors");
		$finish;
	end

endmodule

[files.f]
+incdir+src
src/hcbd_pkg.sv
src/hcbd_ifs.sv
src/hcbd_cfg.sv
src/hcbd_core.sv
src/hcbd_outreg.sv
src/http_chunked_body_decoder_unit.sv
tb/tb.sv
